// ----- rtl/ils_pkg.sv -----
// shared types and codes for the indexed list store
`timescale 1ns / 1ps

package ils_pkg;

    localparam int KIND_W  = 2;
    localparam int POS_W   = 5;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd2;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_BAD_POS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    localparam logic signed [VALUE_W-1:0] VALUE_NONE = -32'sd1;

    typedef struct packed {
        logic [KIND_W-1:0]         kind;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } ils_req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        logic [STAT_W-1:0]         status;
        logic [COUNT_W-1:0]        count;
    } ils_rsp_t;

endpackage

// ----- rtl/ils_ram.sv -----
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps

module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/indexed_list_store_unit.sv -----
// Ordered list of up to CAPACITY signed 32-bit values with insert, delete and get
// requests at a position counted from the head. Entries sit in one ram with a
// registered read port, and a small sequencer moves them one at a time through
// that port: each entry moved is read, then written back one place over. A get
// reads its entry once, and a rejected request moves nothing; each then loads the
// result register, and that load waits while an earlier result is still held on
// the output. s_ready is low while a request is being worked and comes back in the
// idle state before the next request is taken. There is no clearing pass after
// reset: only entries below the count are ever used.
`timescale 1ns / 1ps

module indexed_list_store_unit #(
    parameter int CAPACITY = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ils_pkg::ils_req_t s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output ils_pkg::ils_rsp_t m_data
);

    import ils_pkg::*;

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int AW   = $clog2(CAPACITY);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_WR,
        S_GET_RD,
        S_GET_DAT,
        S_RESP
    } state_t;

    state_t                    state_reg;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             idx_reg;
    logic [CW-1:0]             pos_reg;
    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] rv_reg;
    logic [STAT_W-1:0]         st_reg;
    logic                      m_valid_reg;
    ils_rsp_t                  m_data_reg;

    logic [CMPW-1:0]    pos_ext;
    logic [CMPW-1:0]    cnt_ext;
    logic [CW-1:0]      nbr_idx;
    logic               ins_more;
    logic               del_more;
    logic               ram_we;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [VALUE_W-1:0] ram_rdata;

    assign pos_ext = CMPW'(s_data.position);
    assign cnt_ext = CMPW'(count_reg);

    // shared step unit: neighbor index one below (insert) or above (delete)
    assign nbr_idx  = ((state_reg == S_INS_RD) || (state_reg == S_INS_WR))
                    ? idx_reg - 1'b1 : idx_reg + 1'b1;
    assign ins_more = idx_reg > pos_reg;
    assign del_more = {1'b0, idx_reg} + 1'b1 < {1'b0, count_reg};

    assign ram_we    = (state_reg == S_INS_WR) || (state_reg == S_DEL_WR)
                    || ((state_reg == S_INS_RD) && !ins_more);
    assign ram_wdata = (state_reg == S_INS_RD) ? val_reg : ram_rdata;
    assign ram_raddr = (state_reg == S_GET_RD) ? idx_reg[AW-1:0] : nbr_idx[AW-1:0];

    ils_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(idx_reg[AW-1:0]),
        .wr_data(ram_wdata),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready && (state_reg != S_RESP)) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        val_reg <= s_data.value;
                        pos_reg <= CW'(s_data.position);
                        case (s_data.kind)
                            KIND_INSERT: begin
                                idx_reg <= count_reg;
                                rv_reg  <= '0;
                                if (pos_ext > cnt_ext) begin
                                    st_reg    <= ST_BAD_POS;
                                    state_reg <= S_RESP;
                                end else if (count_reg == CAP_CNT) begin
                                    st_reg    <= ST_FULL;
                                    state_reg <= S_RESP;
                                end else begin
                                    st_reg    <= ST_DONE;
                                    state_reg <= S_INS_RD;
                                end
                            end
                            KIND_DELETE: begin
                                idx_reg <= CW'(s_data.position);
                                rv_reg  <= '0;
                                st_reg  <= ST_BAD_POS;
                                if (pos_ext >= cnt_ext) begin
                                    state_reg <= S_RESP;
                                end else begin
                                    state_reg <= S_DEL_RD;
                                end
                            end
                            KIND_GET: begin
                                idx_reg <= CW'(s_data.position);
                                st_reg  <= ST_BAD_POS;
                                if (pos_ext >= cnt_ext) begin
                                    rv_reg    <= VALUE_NONE;
                                    state_reg <= S_RESP;
                                end else begin
                                    rv_reg    <= '0;
                                    state_reg <= S_GET_RD;
                                end
                            end
                            default: begin
                                idx_reg   <= CW'(s_data.position);
                                rv_reg    <= '0;
                                st_reg    <= ST_BAD_POS;
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_INS_RD: begin
                    if (ins_more) begin
                        state_reg <= S_INS_WR;
                    end else begin
                        // new value written at the hole, list grows
                        count_reg <= count_reg + 1'b1;
                        st_reg    <= ST_DONE;
                        state_reg <= S_RESP;
                    end
                end
                S_INS_WR: begin
                    idx_reg   <= nbr_idx;
                    state_reg <= S_INS_RD;
                end
                S_DEL_RD: begin
                    if (del_more) begin
                        state_reg <= S_DEL_WR;
                    end else begin
                        count_reg <= count_reg - 1'b1;
                        st_reg    <= ST_DONE;
                        state_reg <= S_RESP;
                    end
                end
                S_DEL_WR: begin
                    idx_reg   <= nbr_idx;
                    state_reg <= S_DEL_RD;
                end
                S_GET_RD: begin
                    state_reg <= S_GET_DAT;
                end
                S_GET_DAT: begin
                    rv_reg    <= ram_rdata;
                    st_reg    <= ST_DONE;
                    state_reg <= S_RESP;
                end
                S_RESP: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg           <= 1'b1;
                        m_data_reg.read_value <= rv_reg;
                        m_data_reg.status     <= st_reg;
                        m_data_reg.count      <= COUNT_W'(count_reg);
                        state_reg             <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CAP_CNT)
        else $error("entry count above capacity");

    a_ins_shift_above_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_INS_WR |-> idx_reg > pos_reg && idx_reg <= count_reg)
        else $error("insert shift outside the moving range");

    a_del_shift_below_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DEL_WR |-> idx_reg >= pos_reg && del_more)
        else $error("delete shift outside the moving range");

    a_count_moves_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && count_reg != $past(count_reg)
            |-> $past(state_reg) == S_INS_RD || $past(state_reg) == S_DEL_RD)
        else $error("entry count changed outside a finishing insert or delete");

    a_full_only_at_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RESP && st_reg == ST_FULL |-> count_reg == CAP_CNT)
        else $error("full status with room left");

endmodule

// ----- tb/tb_indexed_list_store_unit.sv -----
// self-checking testbench for the indexed list store unit
`timescale 1ns / 1ps

module tb_indexed_list_store_unit;
    import ils_pkg::*;

    localparam int LIST_CAP       = 16;
    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    // the fourth kind code has no operation behind it
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    typedef enum int { MIX_GROW, MIX_SHRINK, MIX_EVEN } mix_t;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ils_req_t s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ils_rsp_t m_data;

    // predicted list contents, updated when a request is accepted
    logic signed [VALUE_W-1:0] list_mem [LIST_CAP];
    int unsigned               list_len = 0;

    ils_rsp_t pending_rsp[$];
    int       error_count  = 0;
    int       req_sent     = 0;
    int       rsp_checked  = 0;
    int       seen_done    = 0;
    int       seen_bad_pos = 0;
    int       seen_full    = 0;
    int       burst_left   = 0;
    int       idle_cycles  = 0;
    bit       hold_req     = 1'b0;

    indexed_list_store_unit #(
        .CAPACITY(LIST_CAP)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic ils_rsp_t predict_list_response(ils_req_t req);
        ils_rsp_t    rsp;
        int unsigned pos;
        int unsigned i;
        rsp.read_value = '0;
        rsp.status     = ST_DONE;
        pos            = req.position;
        case (req.kind)
            KIND_INSERT: begin
                // position is checked before fullness
                if (pos > list_len) begin
                    rsp.status = ST_BAD_POS;
                end else if (list_len >= LIST_CAP) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (i = list_len; i > pos; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[pos] = req.value;
                    list_len++;
                end
            end
            KIND_DELETE: begin
                if (pos >= list_len) begin
                    rsp.status = ST_BAD_POS;
                end else begin
                    for (i = pos; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            end
            KIND_GET: begin
                if (pos >= list_len) begin
                    rsp.status     = ST_BAD_POS;
                    rsp.read_value = VALUE_NONE;
                end else begin
                    rsp.read_value = list_mem[pos];
                end
            end
            default: begin
                rsp.status = ST_BAD_POS;
            end
        endcase
        rsp.count = COUNT_W'(list_len);
        return rsp;
    endfunction

    function automatic ils_req_t make_req(logic [KIND_W-1:0] kind, int pos,
                                          logic signed [VALUE_W-1:0] value);
        ils_req_t req;
        req.kind     = kind;
        req.position = POS_W'(pos);
        req.value    = value;
        return req;
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        logic signed [VALUE_W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
                0: v = VAL_MAX;
                1: v = VAL_MIN;
                2: v = '0;
                default: v = -32'sd1;
            endcase
        end
        return v;
    endfunction

    function automatic ils_req_t pick_request(mix_t mix);
        ils_req_t    req;
        int unsigned roll;
        req.value = pick_value();
        // a slice of plain noise: any kind, any position
        if ($urandom_range(0, 9) == 0) begin
            req.kind     = KIND_W'($urandom_range(0, 3));
            req.position = POS_W'($urandom_range(0, 31));
            return req;
        end
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_GROW:   req.kind = (roll < 60) ? KIND_INSERT :
                                   (roll < 85) ? KIND_GET : KIND_DELETE;
            MIX_SHRINK: req.kind = (roll < 60) ? KIND_DELETE :
                                   (roll < 85) ? KIND_GET : KIND_INSERT;
            default:    req.kind = (roll < 35) ? KIND_INSERT :
                                   (roll < 70) ? KIND_GET : KIND_DELETE;
        endcase
        if ($urandom_range(0, 15) == 0) begin
            // just past the valid range
            req.position = POS_W'(list_len + ((req.kind == KIND_INSERT) ? 1 : 0)
                                  + $urandom_range(0, 2));
        end else if (req.kind == KIND_INSERT) begin
            case ($urandom_range(0, 3))
                0:       req.position = '0;
                1:       req.position = POS_W'(list_len);
                default: req.position = POS_W'($urandom_range(0, list_len));
            endcase
        end else if (list_len == 0) begin
            req.position = '0;
        end else if ($urandom_range(0, 3) == 0) begin
            // work from the head, so the list often empties that way
            req.position = '0;
        end else begin
            req.position = POS_W'($urandom_range(0, list_len - 1));
        end
        return req;
    endfunction

    // drive one request and hold it until accepted; gaps come between bursts
    task automatic send_request(ils_req_t req);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
        burst_left--;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        pending_rsp.push_back(predict_list_response(req));
        req_sent++;
    endtask

    task automatic release_input();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic wait_for_results();
        while (pending_rsp.size() != 0) @(posedge aclk);
    endtask

    task automatic test_directed_edges();
        int unsigned i;
        int          pos;
        // empty list: every access misses, unused kind is rejected
        send_request(make_req(KIND_GET, 0, '0));
        send_request(make_req(KIND_DELETE, 0, '0));
        send_request(make_req(KIND_INSERT, 1, 32'sd5));
        send_request(make_req(KIND_UNUSED, 0, VAL_MAX));
        // head insert, then empty the list from the head down to the last element
        send_request(make_req(KIND_INSERT, 0, VAL_MAX));
        send_request(make_req(KIND_INSERT, 0, VAL_MIN));
        send_request(make_req(KIND_DELETE, 0, '0));
        send_request(make_req(KIND_DELETE, 0, '0));
        // fill to capacity using head, tail and middle positions
        for (i = 0; i < LIST_CAP; i++) begin
            pos = (i % 3 == 0) ? 0 : (i % 3 == 1) ? list_len : list_len / 2;
            send_request(make_req(KIND_INSERT, pos,
                                  (i == 0) ? VAL_MAX : (i == 1) ? VAL_MIN : pick_value()));
        end
        send_request(make_req(KIND_INSERT, LIST_CAP, 32'sd7));
        send_request(make_req(KIND_INSERT, LIST_CAP + 1, 32'sd7));
    endtask

    task automatic test_random_phases(int n_items);
        int   phase_left;
        mix_t mix;
        phase_left = 0;
        mix        = MIX_EVEN;
        repeat (n_items) begin
            if (phase_left == 0) begin
                phase_left = $urandom_range(20, 120);
                case ($urandom_range(0, 2))
                    0:       mix = MIX_GROW;
                    1:       mix = MIX_SHRINK;
                    default: mix = MIX_EVEN;
                endcase
            end
            phase_left--;
            send_request(pick_request(mix));
        end
    endtask

    // receiver stops for a long stretch while requests keep coming
    task automatic test_receiver_holdoff();
        hold_req = 1'b1;
        repeat (24) send_request(pick_request(MIX_EVEN));
    endtask

    // sender goes quiet until the last response is in, then resumes
    task automatic test_quiet_pause();
        release_input();
        wait_for_results();
        repeat (30) send_request(pick_request(MIX_GROW));
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_edges();
        test_random_phases(800);
        test_receiver_holdoff();
        test_quiet_pause();
        test_random_phases(770);
        release_input();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("run covered %0d requests, %0d responses checked", req_sent, rsp_checked);
        $display("statuses seen: %0d done, %0d bad position, %0d list full",
                 seen_done, seen_bad_pos, seen_full);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // receiver stall pattern, with an optional long hold-off on request
    initial begin
        int mode_left;
        int rx_mode;
        int phase;
        mode_left = 0;
        rx_mode   = 0;
        phase     = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(64, 256);
                    rx_mode   = $urandom_range(0, 3);
                end
                mode_left--;
                phase++;
                case (rx_mode)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= 1'($urandom_range(0, 1));
                    2:       m_ready <= ($urandom_range(0, 4) != 0);
                    default: m_ready <= (phase % 5 != 0);
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        ils_rsp_t exp_rsp;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: response with nothing outstanding: %p", $time, m_data);
                error_count++;
            end else begin
                exp_rsp = pending_rsp.pop_front();
                rsp_checked++;
                case (exp_rsp.status)
                    ST_DONE:    seen_done++;
                    ST_FULL:    seen_full++;
                    default:    seen_bad_pos++;
                endcase
                if (m_data.read_value !== exp_rsp.read_value) begin
                    $display("%0t: read_value expected %0d got %0d",
                             $time, exp_rsp.read_value, m_data.read_value);
                    error_count++;
                end
                if (m_data.status !== exp_rsp.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, exp_rsp.status, m_data.status);
                    error_count++;
                end
                if (m_data.count !== exp_rsp.count) begin
                    $display("%0t: count expected %0d got %0d",
                             $time, exp_rsp.count, m_data.count);
                    error_count++;
                end
            end
        end
    end

    // ends the run if no handshake happens on either side for too long
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no handshake for %0d cycles, %0d responses outstanding",
                         $time, idle_cycles, pending_rsp.size());
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule

// ----- sim.f -----
rtl/ils_pkg.sv
rtl/ils_ram.sv
rtl/indexed_list_store_unit.sv
tb/tb_indexed_list_store_unit.sv
